// ----- src/dgn_pkg.sv -----
// Package: shared sizes, row type, action codes, status codes and register indices of the gain normalizer.
`timescale 1ns / 1ps
package dgn_pkg;
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int TIME_W = 48;
	localparam int MASK_W = 5;
	localparam int SENS_W = 12;
	localparam int NUM_W = 15;
	localparam int DEN_W = 15;
	localparam int DIVD_W = 47;
	localparam int CFG_W = 48;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_CORRECT = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ST_SCALED = 2'd0;
	localparam logic [1:0] ST_NO_UNIT = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [2:0] REG_NUM = 3'd0;
	localparam logic [2:0] REG_SENS0 = 3'd1;
	localparam logic [2:0] REG_SENS1 = 3'd2;
	localparam logic [2:0] REG_SENS2 = 3'd3;
	localparam logic [2:0] REG_SENS3 = 3'd4;
	localparam logic [2:0] REG_SENS4 = 3'd5;
	localparam logic [2:0] REG_WIDTH = 3'd6;
	localparam logic [2:0] REG_OFFSET = 3'd7;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [TIME_W-1:0] stamp;
	} row_t;
endpackage

// ----- src/detector_gain_normalizer_top.sv -----
// Top level: configuration, row table sequencer and scaling of corrected bins.
`timescale 1ns / 1ps
// Detector gain normalizer. Append items (tuser 0) add a row of time stamp and
// unit mask to a table of up to 4096 rows; clear items (tuser 2) empty it.
// A correct item (tuser 1) scans the table row by row from the start, through
// the single table read port, to find the row holding the bin start, scans on
// from there for the row of the bin end, reads both masks, then runs the
// shared 47-bit restoring divider twice, once for rate and once for error
// (skipped for an invalid bin or when no unit is on). An empty table skips
// the search and answers with zeros. The input is not ready while an item is
// worked on. A finished result sits in the output register, and appends and
// clears are still taken while it waits.
module detector_gain_normalizer_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [47:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// stamp[47:0], unit_mask[52:48], rate_in[84:53], error_in[116:85], zero pad
	input  logic [119:0] s_tdata,
	// action[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rate_out[31:0], error_out[63:32]
	output logic [63:0]  m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser
);
	import dgn_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;
	localparam logic [3:0] S_CK = 4'd2;
	localparam logic [3:0] S_MJ = 4'd3;
	localparam logic [3:0] S_MK = 4'd4;
	localparam logic [3:0] S_MC = 4'd5;
	localparam logic [3:0] S_MUL = 4'd6;
	localparam logic [3:0] S_DST = 4'd7;
	localparam logic [3:0] S_DWT = 4'd8;
	localparam logic [3:0] S_EMIT = 4'd9;

	localparam int X_W = 51;

	// configuration registers
	logic [NUM_W-1:0] num_q;
	logic [SENS_W-1:0] sens_q [5];
	logic [31:0] width_q;
	logic [TIME_W-1:0] offset_q;

	logic [3:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] a_q, f_q, j_q, k_q;
	logic second_q;            // low: searching start row, high: end row
	logic [X_W-1:0] x_q, end_q;
	logic [TIME_W-1:0] prev_q;
	logic [MASK_W-1:0] mj_q;
	logic [DEN_W-1:0] den_q;
	logic neg_q;
	logic [31:0] mag_q, err_q;
	logic sel_q;               // low: rate pass, high: error pass
	logic [DIVD_W-1:0] prod_q;
	logic [31:0] rres_q, eres_q;
	logic [1:0] stat_q;
	logic m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	logic [IDX_W-1:0] last;
	logic [TIME_W-1:0] in_stamp;
	logic [MASK_W-1:0] in_mask;
	logic [31:0] in_rate, in_err;
	logic accept;
	logic tbl_we;
	logic [IDX_W-1:0] raddr;
	row_t rrow, wrow;
	logic hit;
	logic [IDX_W-1:0] row_c;
	logic [DEN_W-1:0] den_c;
	logic [31:0] q32;
	logic q_hi;
	logic div_start, div_busy, div_done;
	logic [DIVD_W-1:0] quo;

	assign last = IDX_W'(count_q - 1'b1);
	assign in_stamp = s_tdata[47:0];
	assign in_mask = s_tdata[52:48];
	assign in_rate = s_tdata[84:53];
	assign in_err = s_tdata[116:85];
	assign s_tready = state_q == S_IDLE;
	assign accept = s_tvalid && s_tready;
	assign tbl_we = accept && s_tuser == ACT_APPEND && count_q < CNT_W'(TABLE_DEPTH);
	assign wrow = '{mask: in_mask, stamp: in_stamp};

	always_comb begin
		unique case (state_q)
			S_MJ: raddr = j_q;
			S_MK: raddr = k_q;
			default: raddr = a_q;
		endcase
	end

	dgn_table u_table (
		.clk(clk), .we(tbl_we), .waddr(count_q[IDX_W-1:0]), .wdata(wrow),
		.raddr(raddr), .rdata(rrow)
	);

	// interval test of the row before the one just read
	assign hit = $signed(x_q) >= $signed({3'b000, prev_q})
		&& $signed(x_q) < $signed({3'b000, rrow.stamp});

	// row a search ends on: hit names the row before, else the last row
	assign row_c = (a_q != f_q && hit) ? a_q - 1'b1 : last;

	always_comb begin
		den_c = '0;
		for (int u = 0; u < MASK_W; u++) begin
			if (mj_q[u]) begin
				den_c = den_c + DEN_W'(sens_q[u]);
			end
		end
	end

	assign div_start = state_q == S_DST;
	dgn_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(prod_q + DIVD_W'(den_q >> 1)), .divisor(den_q),
		.busy(div_busy), .done(div_done), .quotient(quo)
	);
	assign q_hi = |quo[DIVD_W-1:32];
	assign q32 = quo[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_W'(2602);
			sens_q[0] <= SENS_W'(2660);
			sens_q[1] <= SENS_W'(2660);
			sens_q[2] <= SENS_W'(2680);
			sens_q[3] <= SENS_W'(2520);
			sens_q[4] <= SENS_W'(2490);
			width_q <= 32'd65536;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_NUM: num_q <= cfg_data[NUM_W-1:0];
				REG_SENS0: sens_q[0] <= cfg_data[SENS_W-1:0];
				REG_SENS1: sens_q[1] <= cfg_data[SENS_W-1:0];
				REG_SENS2: sens_q[2] <= cfg_data[SENS_W-1:0];
				REG_SENS3: sens_q[3] <= cfg_data[SENS_W-1:0];
				REG_SENS4: sens_q[4] <= cfg_data[SENS_W-1:0];
				REG_WIDTH: width_q <= cfg_data[31:0];
				REG_OFFSET: offset_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// load the output register once it is free, else drop it when taken
			if (state_q == S_EMIT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (tbl_we) begin
							count_q <= count_q + 1'b1;
						end else if (s_tuser == ACT_CLEAR) begin
							count_q <= '0;
						end else if (s_tuser == ACT_CORRECT) begin
							state_q <= count_q == '0 ? S_EMIT : S_RD;
						end
					end
				end
				S_RD: state_q <= S_CK;
				S_CK: begin
					if (a_q == f_q && a_q != last) begin
						state_q <= S_RD;
					end else if (a_q == f_q || hit || a_q == last) begin
						state_q <= second_q ? S_MJ : S_RD;
					end else begin
						state_q <= S_RD;
					end
				end
				S_MJ: state_q <= S_MK;
				S_MK: state_q <= S_MC;
				S_MC: begin
					if (mj_q != rrow.mask || den_c == '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_DST;
				S_DST: state_q <= S_DWT;
				S_DWT: begin
					if (div_done) begin
						state_q <= sel_q ? S_EMIT : S_MUL;
					end
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				x_q <= X_W'($signed({3'b000, in_stamp})) + X_W'($signed(offset_q));
				neg_q <= in_rate[31];
				mag_q <= in_rate[31] ? 32'(-in_rate) : in_rate;
				err_q <= in_err;
				a_q <= '0;
				f_q <= '0;
				second_q <= 1'b0;
				sel_q <= 1'b0;
				stat_q <= ST_EMPTY;
				// an empty table answers with zeros
				if (s_tuser == ACT_CORRECT && count_q == '0) begin
					rres_q <= '0;
					eres_q <= '0;
				end else begin
					rres_q <= in_rate;
					eres_q <= in_err;
				end
			end
			S_CK: begin
				prev_q <= rrow.stamp;
				if (a_q == f_q && a_q != last) begin
					a_q <= a_q + 1'b1;
				end else if (a_q == f_q || hit || a_q == last) begin
					if (!second_q) begin
						j_q <= row_c;
						f_q <= row_c;
						a_q <= row_c;
						x_q <= x_q + X_W'(width_q);
						second_q <= 1'b1;
					end else if (row_c == j_q) begin
						// both ends in one row: advance to the next row, stop at the last
						k_q <= (j_q == last) ? last : j_q + 1'b1;
					end else begin
						k_q <= row_c;
					end
				end else begin
					a_q <= a_q + 1'b1;
				end
			end
			S_MK: mj_q <= rrow.mask;
			S_MC: begin
				den_q <= den_c;
				if (mj_q != rrow.mask) begin
					stat_q <= ST_INVALID;
					rres_q <= '0;
					eres_q <= '0;
				end else if (den_c == '0) begin
					stat_q <= ST_NO_UNIT;
				end else begin
					stat_q <= ST_SCALED;
				end
			end
			S_MUL: prod_q <= DIVD_W'((sel_q ? err_q : mag_q) * num_q);
			S_DWT: begin
				if (div_done) begin
					sel_q <= 1'b1;
					if (sel_q) begin
						eres_q <= q_hi ? '1 : q32;
					end else if (neg_q) begin
						rres_q <= (q_hi || q32 > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q32);
					end else begin
						rres_q <= (q_hi || q32[31]) ? 32'h7FFF_FFFF : q32;
					end
				end
			end
			S_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {eres_q, rres_q};
					m_tuser_q <= stat_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("row count beyond table depth");
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_DWT)
		else $error("divider runs outside its wait state");
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_EMIT))
		else $error("result raised without emit state");
endmodule

// ----- src/dgn_table.sv -----
// Row table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module dgn_table (
	input  logic                 clk,
	input  logic                 we,
	input  logic [dgn_pkg::IDX_W-1:0] waddr,
	input  dgn_pkg::row_t        wdata,
	input  logic [dgn_pkg::IDX_W-1:0] raddr,
	output dgn_pkg::row_t        rdata
);
	import dgn_pkg::*;

	row_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/dgn_div.sv -----
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module dgn_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dgn_pkg::DIVD_W-1:0] dividend,
	input  logic [dgn_pkg::DEN_W-1:0]  divisor,
	output logic                      busy,
	output logic                      done,
	output logic [dgn_pkg::DIVD_W-1:0] quotient
);
	import dgn_pkg::*;

	localparam int CW = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] w_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic done_q;
	logic [DEN_W:0] trial;
	logic ge;

	assign trial = {rem_q, w_q[DIVD_W-1]};
	assign ge = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DIVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= dividend;
			rem_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			w_q <= {w_q[DIVD_W-2:0], ge};
			rem_q <= ge ? DEN_W'(trial - {1'b0, d_q}) : trial[DEN_W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign done = done_q;
	assign quotient = w_q;
endmodule
